// ===== design/jpc_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// jpc_pkg
// Shared widths, constants and types for the Jacobi coefficient unit.
// ---------------------------------------------------------------------------
package jpc_pkg;

  localparam int MAX_DEGREE = 16;
  localparam int KW = $clog2(MAX_DEGREE + 1);
  localparam int ONE_Q16 = 65536;
  // recurrence factors in signed Q.16
  localparam int FW = 28;
  // shared multiplier operand and product widths
  localparam int MA = 48;
  localparam int MB = 64;
  localparam int MP = MA + MB;
  // exact recurrence sum
  localparam int SW = 128;
  localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;

  typedef struct packed {
    logic          start;
    logic [MA-1:0] a;
    logic [MB-1:0] b;
  } mul_req_t;

  function automatic logic [FW-1:0] fmag(input logic signed [FW-1:0] v);
    logic [FW-1:0] r;
    r = v[FW-1] ? FW'(-v) : FW'(v);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/jpc_mul.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// jpc_mul
// Unsigned 48 x 64 multiplier, four 24 x 32 partial products, one per cycle.
// ---------------------------------------------------------------------------
module jpc_mul
  import jpc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  mul_req_t      req,
  output logic          done,
  output logic [MP-1:0] product
);

  localparam int AH = MA / 2;
  localparam int BH = MB / 2;

  logic [MA-1:0]      a_r;
  logic [MB-1:0]      b_r;
  logic [2:0]         cnt;
  logic               busy;
  logic [AH+BH-1:0]   pp;
  logic [1:0]         psh;
  logic [AH-1:0]      a_part;
  logic [BH-1:0]      b_part;
  logic [MP-1:0]      pp_ext;
  logic [MP-1:0]      pp_sh;

  always_comb begin
    a_part = cnt[1] ? a_r[MA-1:AH] : a_r[AH-1:0];
    b_part = cnt[0] ? b_r[MB-1:BH] : b_r[BH-1:0];
    pp_ext = MP'(pp);
    case (psh)
      2'd0:    pp_sh = pp_ext;
      2'd1:    pp_sh = pp_ext << BH;
      2'd2:    pp_sh = pp_ext << AH;
      default: pp_sh = pp_ext << (AH + BH);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // partial product registered, then accumulated in the next cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r     <= req.a;
      b_r     <= req.b;
      product <= '0;
    end else if (busy) begin
      if (cnt != 3'd4) begin
        pp  <= {{BH{1'b0}}, a_part} * {{AH{1'b0}}, b_part};
        psh <= cnt[1:0];
      end
      if (cnt != 3'd0) begin
        product <= product + pp_sh;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/jpc_div.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// jpc_div
// Signed (num << 16) / den with rounding and saturation, one quotient bit
// per cycle.
// ---------------------------------------------------------------------------
module jpc_div
  import jpc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [SW-1:0] num,
  input  logic [63:0]   den,
  output logic          done,
  output logic [63:0]   quotient
);

  typedef enum logic [4:0] {
    D_IDLE = 5'b00001,
    D_PREP = 5'b00010,
    D_CHK  = 5'b00100,
    D_RUN  = 5'b01000,
    D_FIN  = 5'b10000
  } dstate_t;

  dstate_t       state;
  logic          neg;
  logic          zero_d;
  logic          sat;
  logic [SW-1:0] mag;
  logic [63:0]   den_r;
  logic [63:0]   rem;
  logic [63:0]   q;
  logic [5:0]    cnt;
  logic [64:0]   trial;

  assign trial = {rem, mag[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: if (start) state <= D_PREP;
        D_PREP: state <= D_CHK;
        D_CHK: begin
          if (den_r == 64'd0 || mag[SW-1:64] >= den_r) begin
            state <= D_FIN;
          end else begin
            state <= D_RUN;
          end
        end
        D_RUN: if (cnt == 6'd63) state <= D_FIN;
        D_FIN: begin
          state <= D_IDLE;
          done  <= 1'b1;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      D_IDLE: begin
        if (start) begin
          neg   <= num[SW-1];
          mag   <= num[SW-1] ? -num : num;
          den_r <= den;
        end
      end
      D_PREP: begin
        // scale to Q.64 and add half the divisor for rounding
        mag <= {mag[SW-17:0], 16'd0} + {64'd0, 1'b0, den_r[63:1]};
      end
      D_CHK: begin
        zero_d <= (den_r == 64'd0);
        sat    <= (mag[SW-1:64] >= den_r);
        rem    <= mag[SW-1:64];
        q      <= '0;
        cnt    <= '0;
      end
      D_RUN: begin
        if (trial >= {1'b0, den_r}) begin
          rem <= 64'(trial - {1'b0, den_r});
          q   <= {q[62:0], 1'b1};
        end else begin
          rem <= trial[63:0];
          q   <= {q[62:0], 1'b0};
        end
        mag[63:0] <= {mag[62:0], 1'b0};
        cnt       <= cnt + 6'd1;
      end
      D_FIN: begin
        if (zero_d) begin
          quotient <= '0;
        end else if (neg) begin
          if (sat || (q[63] && q[62:0] != '0)) quotient <= {1'b1, 63'd0};
          else quotient <= -q;
        end else begin
          if (sat || q[63]) quotient <= {1'b0, {63{1'b1}}};
          else quotient <= q;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/jacobi_polynomial_coefficients_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// jacobi_polynomial_coefficients_unit
// Power-basis coefficients of P_n^(alpha,beta) by the three-term recurrence.
// ---------------------------------------------------------------------------
// One request is worked at a time. Each product on the shared multiplier is
// built from four partial products. Terms known to be zero skip the
// multiplier. The bit-serial 128/64 divider runs once per coefficient. Step
// i builds i+2 coefficients from 3i+2 term products, after eight factor
// set-up products. After the last step each beat is read (S_EMIT_RD) and
// then sent (S_EMIT), holding while the sink stalls. A bad parameter
// answers with one beat from S_BAD. Coefficient vectors live in one
// single-port-read memory of three rotating banks (previous, current,
// next).
module jacobi_polynomial_coefficients_unit
  import jpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               request_valid,
  output logic               request_ready,
  input  logic signed [23:0] alpha,
  input  logic signed [23:0] beta,
  input  logic [4:0]         degree,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [63:0] coefficient,
  output logic [4:0]         power_index,
  output logic               last,
  output logic               bad_parameter
);

  localparam int AW = KW + 2;
  localparam int MEM_DEPTH = 3 * (1 << KW);
  localparam logic signed [23:0] NEG_ONE = -24'sd65536;

  typedef enum logic [12:0] {
    S_IDLE       = 13'b0000000000001,
    S_BAD        = 13'b0000000000010,
    S_INIT       = 13'b0000000000100,
    S_STEP       = 13'b0000000001000,
    S_SETUP_GO   = 13'b0000000010000,
    S_SETUP_WAIT = 13'b0000000100000,
    S_TERM_RD    = 13'b0000001000000,
    S_TERM_MUL   = 13'b0000010000000,
    S_TERM_WAIT  = 13'b0000100000000,
    S_DIV_GO     = 13'b0001000000000,
    S_DIV_WAIT   = 13'b0010000000000,
    S_EMIT_RD    = 13'b0100000000000,
    S_EMIT       = 13'b1000000000000
  } state_t;

  typedef enum logic [2:0] {
    OP_F1F2, OP_A1, OP_T2, OP_A2, OP_T3, OP_A3, OP_T4, OP_A4
  } op_t;

  typedef enum logic [1:0] {
    T_CUR, T_LOW, T_PREV
  } term_t;

  state_t              state;
  op_t                 op;
  term_t               term;
  logic signed [23:0]  alpha_r;
  logic signed [23:0]  beta_r;
  logic [KW-1:0]       n_r;
  logic [KW-1:0]       step_count;
  logic [KW-1:0]       k;
  logic [1:0]          prev_b;
  logic [1:0]          cur_b;
  logic [1:0]          nxt_b;
  logic [63:0]         m1;
  logic [63:0]         a1;
  logic                a1_neg;
  logic [MA-1:0]       tmp;
  logic                tmp_s;
  logic [MA-1:0]       a2;
  logic [MA-1:0]       a3;
  logic [MA-1:0]       a4;
  logic                a2_s;
  logic                a3_s;
  logic                a4_s;
  logic                t_sign;
  logic [SW-1:0]       acc;

  logic signed [FW-1:0] c;
  logic signed [FW-1:0] g;
  logic signed [FW-1:0] ii;
  logic signed [FW-1:0] one;
  logic signed [FW-1:0] f1;
  logic signed [FW-1:0] f2;
  logic signed [FW-1:0] f3;
  logic signed [FW-1:0] f4;
  logic signed [FW-1:0] ap;
  logic signed [FW-1:0] bp;
  logic [KW:0]          i_inc;
  logic [63:0]          rnd_sum;
  logic [MA-1:0]        rnd;
  logic [63:0]          coef_mag;
  logic                 term_zero;
  logic [MA-1:0]        term_mag;
  logic                 term_s;
  logic [KW-1:0]        deg_sat;
  logic                 bad_in;
  logic                 out_free;

  mul_req_t             mul_req;
  logic                 mul_done;
  logic [MP-1:0]        product;
  logic                 div_start;
  logic                 div_done;
  logic [63:0]          quotient;

  logic [63:0]          mem [MEM_DEPTH];
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [63:0]          rdata;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [63:0]          wr_data;

  jpc_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .done    (mul_done),
    .product (product)
  );

  jpc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (acc),
    .den      (a1),
    .done     (div_done),
    .quotient (quotient)
  );

  // recurrence factors for the current step
  always_comb begin
    one   = FW'(ONE_Q16);
    c     = FW'(alpha_r) + FW'(beta_r);
    g     = FW'(alpha_r) - FW'(beta_r);
    ii    = $signed(FW'({step_count, 16'd0}));
    f1    = ii + one + c;
    f2    = (ii <<< 1) + c;
    f3    = f2 + one;
    f4    = f2 + (one <<< 1);
    ap    = FW'(alpha_r) + ii;
    bp    = FW'(beta_r) + ii;
    i_inc = {1'b0, step_count} + (KW+1)'(1);
    rnd_sum = product[63:0] + 64'd32768;
    rnd     = rnd_sum[63:16];
  end

  assign request_ready = (state == S_IDLE);
  assign out_free      = !result_valid || result_ready;
  assign deg_sat       = (degree > 5'(MAX_DEGREE)) ? KW'(MAX_DEGREE) : KW'(degree);
  assign bad_in        = (alpha <= NEG_ONE) || (beta <= NEG_ONE);
  assign coef_mag      = rdata[63] ? -rdata : rdata;
  assign div_start     = (state == S_DIV_GO);

  // which recurrence term, and whether it is known to be zero
  always_comb begin
    case (term)
      T_CUR: begin
        term_zero = (k > step_count);
        term_mag  = a2;
        term_s    = a2_s;
      end
      T_LOW: begin
        term_zero = (k == '0);
        term_mag  = a3;
        term_s    = a3_s;
      end
      default: begin
        term_zero = (k >= step_count);
        term_mag  = a4;
        term_s    = ~a4_s;
      end
    endcase
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state)
      S_INIT: begin
        wr_en = 1'b1;
        if (k == KW'(0)) begin
          wr_addr = {prev_b, KW'(0)};
          wr_data = ONE_Q32;
        end else if (k == KW'(1)) begin
          wr_addr = {cur_b, KW'(0)};
          wr_data = 64'(g) << 15;
        end else begin
          wr_addr = {cur_b, KW'(1)};
          wr_data = (64'(c) << 15) + ONE_Q32;
        end
      end
      S_TERM_RD: begin
        rd_en = !term_zero;
        case (term)
          T_CUR:   rd_addr = {cur_b, k};
          T_LOW:   rd_addr = {cur_b, k - KW'(1)};
          default: rd_addr = {prev_b, k};
        endcase
      end
      S_DIV_WAIT: begin
        wr_en   = div_done;
        wr_addr = {nxt_b, k};
        wr_data = quotient;
      end
      S_EMIT_RD: begin
        rd_en   = 1'b1;
        rd_addr = {(n_r == '0) ? prev_b : cur_b, k};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  // multiplier operand selection
  always_comb begin
    mul_req = '0;
    if (state == S_SETUP_GO) begin
      mul_req.start = 1'b1;
      case (op)
        OP_F1F2: begin
          mul_req.a = MA'(fmag(f1));
          mul_req.b = MB'(fmag(f2));
        end
        OP_A1: begin
          mul_req.a = MA'({i_inc, 1'b0});
          mul_req.b = m1;
        end
        OP_T2: begin
          mul_req.a = MA'(fmag(f3));
          mul_req.b = MB'(fmag(c));
        end
        OP_A2: begin
          mul_req.a = tmp;
          mul_req.b = MB'(fmag(g));
        end
        OP_T3: begin
          mul_req.a = MA'(fmag(f2));
          mul_req.b = MB'(fmag(f3));
        end
        OP_T4: begin
          mul_req.a = MA'(fmag(ap));
          mul_req.b = MB'(fmag(bp));
        end
        default: begin
          mul_req.a = tmp;
          mul_req.b = MB'(fmag(f4));
        end
      endcase
    end else if (state == S_TERM_MUL) begin
      mul_req.start = 1'b1;
      mul_req.a     = term_mag;
      mul_req.b     = coef_mag;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (request_valid) state <= bad_in ? S_BAD : S_INIT;
        end
        S_BAD: if (out_free) state <= S_IDLE;
        S_INIT: if (k == KW'(2)) state <= S_STEP;
        S_STEP: state <= (step_count < n_r) ? S_SETUP_GO : S_EMIT_RD;
        S_SETUP_GO: state <= S_SETUP_WAIT;
        S_SETUP_WAIT: begin
          if (mul_done) state <= (op == OP_A4) ? S_TERM_RD : S_SETUP_GO;
        end
        S_TERM_RD: begin
          if (!term_zero) state <= S_TERM_MUL;
          else if (term == T_PREV) state <= S_DIV_GO;
        end
        S_TERM_MUL: state <= S_TERM_WAIT;
        S_TERM_WAIT: begin
          if (mul_done) state <= (term == T_PREV) ? S_DIV_GO : S_TERM_RD;
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) state <= ((KW+1)'(k) == i_inc) ? S_STEP : S_TERM_RD;
        end
        S_EMIT_RD: state <= S_EMIT;
        S_EMIT: begin
          if (out_free) state <= (k == n_r) ? S_IDLE : S_EMIT_RD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (request_valid) begin
          alpha_r <= alpha;
          beta_r  <= beta;
          n_r     <= deg_sat;
          k       <= '0;
          prev_b  <= 2'd0;
          cur_b   <= 2'd1;
          nxt_b   <= 2'd2;
        end
      end
      S_INIT: begin
        k <= k + KW'(1);
        step_count <= KW'(1);
      end
      S_STEP: begin
        op <= OP_F1F2;
        k  <= '0;
      end
      S_SETUP_WAIT: begin
        if (mul_done) begin
          case (op)
            OP_F1F2: begin
              m1     <= product[63:0];
              a1_neg <= f1[FW-1] ^ f2[FW-1];
              op     <= OP_A1;
            end
            OP_A1: begin
              a1 <= product[63:0];
              op <= OP_T2;
            end
            OP_T2: begin
              tmp   <= rnd;
              tmp_s <= f3[FW-1] ^ c[FW-1];
              op    <= OP_A2;
            end
            OP_A2: begin
              a2   <= rnd;
              a2_s <= tmp_s ^ g[FW-1];
              op   <= OP_T3;
            end
            OP_T3: begin
              tmp   <= rnd;
              tmp_s <= f2[FW-1] ^ f3[FW-1];
              op    <= OP_A3;
            end
            OP_A3: begin
              a3   <= rnd;
              a3_s <= tmp_s ^ f4[FW-1];
              op   <= OP_T4;
            end
            OP_T4: begin
              tmp   <= rnd;
              tmp_s <= ap[FW-1] ^ bp[FW-1];
              op    <= OP_A4;
            end
            default: begin
              a4   <= {rnd[MA-2:0], 1'b0};
              a4_s <= tmp_s ^ f4[FW-1];
              k    <= '0;
              term <= T_CUR;
              acc  <= '0;
            end
          endcase
        end
      end
      S_TERM_RD: begin
        if (term_zero) begin
          case (term)
            T_CUR:   term <= T_LOW;
            T_LOW:   term <= T_PREV;
            default: term <= T_PREV;
          endcase
        end
      end
      S_TERM_MUL: begin
        // sign of the product, with the divisor sign folded in
        t_sign <= term_s ^ rdata[63] ^ a1_neg;
      end
      S_TERM_WAIT: begin
        if (mul_done) begin
          acc <= acc + ({SW{t_sign}} ^ SW'(product)) + SW'(t_sign);
          case (term)
            T_CUR:   term <= T_LOW;
            T_LOW:   term <= T_PREV;
            default: term <= T_PREV;
          endcase
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          term <= T_CUR;
          acc  <= '0;
          if ((KW+1)'(k) == i_inc) begin
            // rotate banks: current becomes previous, next becomes current
            prev_b     <= cur_b;
            cur_b      <= nxt_b;
            nxt_b      <= prev_b;
            step_count <= KW'(i_inc);
          end else begin
            k <= k + KW'(1);
          end
        end
      end
      S_EMIT: begin
        if (out_free && k != n_r) k <= k + KW'(1);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == S_BAD || state == S_EMIT) && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_BAD && out_free) begin
      coefficient   <= '0;
      power_index   <= '0;
      last          <= 1'b1;
      bad_parameter <= 1'b1;
    end else if (state == S_EMIT && out_free) begin
      coefficient   <= rdata;
      power_index   <= 5'(k);
      last          <= (k == n_r);
      bad_parameter <= 1'b0;
    end
  end

  a_mul_done_expected: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_SETUP_WAIT || state == S_TERM_WAIT))
    else $error("multiplier finished outside a wait state");

  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_bad_single_beat: assert property (@(posedge clk) disable iff (rst)
    (result_valid && bad_parameter) |-> (last && power_index == 5'd0))
    else $error("error beat not a single last beat");

  a_k_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_TERM_RD) |-> ((KW+1)'(k) <= i_inc))
    else $error("coefficient index beyond step degree");

endmodule
`default_nettype wire

// ===== tb/tb_jacobi_polynomial_coefficients_unit.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_jacobi_polynomial_coefficients_unit
// Requests of alpha, beta and degree go in through a queued driver. Each
// accepted request is run through an exact fixed-point Jacobi recurrence,
// and every coefficient beat is checked against it in order.
// ---------------------------------------------------------------------------
module tb_jacobi_polynomial_coefficients_unit;
  import jpc_pkg::*;

  localparam int LIMIT = 20000000;
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    logic signed [23:0] alpha;
    logic signed [23:0] beta;
    logic [4:0]         degree;
  } request_t;

  typedef struct {
    logic [63:0] coefficient;
    logic [4:0]  power_index;
    logic        last;
    logic        bad_parameter;
  } coeff_beat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               request_valid = 1'b0;
  logic               request_ready;
  logic signed [23:0] alpha = '0;
  logic signed [23:0] beta = '0;
  logic [4:0]         degree = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic signed [63:0] coefficient;
  logic [4:0]         power_index;
  logic               last;
  logic               bad_parameter;

  request_t    pending_requests[$];
  coeff_beat_t expected_coeffs[$];
  int          errors = 0;
  int          requests_taken = 0;
  int          beats_checked = 0;
  int          bad_requests = 0;
  int          deep_requests = 0;
  int          cycles = 0;
  int          hold_count = 0;
  bit          hold_done = 1'b0;

  jacobi_polynomial_coefficients_unit dut (
    .clk(clk), .rst(rst),
    .request_valid(request_valid), .request_ready(request_ready),
    .alpha(alpha), .beta(beta), .degree(degree),
    .result_valid(result_valid), .result_ready(result_ready),
    .coefficient(coefficient), .power_index(power_index),
    .last(last), .bad_parameter(bad_parameter)
  );

  always #1 clk = ~clk;

  // product of two Q.16 values back to Q.16, halves away from zero
  function automatic longint q16_product(input longint x, input longint y);
    logic [63:0] mx, my, m, r;
    mx = (x < 0) ? 64'(-x) : 64'(x);
    my = (y < 0) ? 64'(-y) : 64'(y);
    m = mx * my;
    r = (m + 64'd32768) >> 16;
    return ((x < 0) != (y < 0)) ? -longint'(r) : longint'(r);
  endfunction

  // signed factor times coefficient bits, exact in 128 bits
  function automatic logic signed [127:0] wide_product(input longint f, input logic [63:0] cf);
    logic signed [127:0] ef, ec;
    ef = {{64{f[63]}}, f};
    ec = {{64{cf[63]}}, cf};
    return ef * ec;
  endfunction

  // (sum << 16) / d rounded and saturated to Q32.32
  function automatic logic [63:0] rounded_quotient(input logic [127:0] sum,
                                                   input logic [63:0] d);
    logic          neg;
    logic [127:0]  n, q;
    if (d == 0) return 64'd0;
    neg = sum[127];
    n = neg ? -sum : sum;
    n = (n << 16) + {64'd0, d >> 1};
    q = n / {64'd0, d};
    if (neg) begin
      if (q[127:64] != 0 || q[63:0] > 64'h8000_0000_0000_0000)
        return 64'h8000_0000_0000_0000;
      return -q[63:0];
    end
    if (q[127:64] != 0 || q[63:0] > 64'h7FFF_FFFF_FFFF_FFFF)
      return 64'h7FFF_FFFF_FFFF_FFFF;
    return q[63:0];
  endfunction

  task automatic predict_coefficients(input request_t rq);
    longint              a, b, c, g, ii, f1, f2, f3, f4, a2, a3, a4;
    logic [63:0]         prev[MAX_DEGREE+1];
    logic [63:0]         cur[MAX_DEGREE+1];
    logic [63:0]         nxt[MAX_DEGREE+1];
    logic [63:0]         a1, m1, m2;
    logic signed [127:0] s;
    int                  n;
    bit                  neg_a1;
    coeff_beat_t         bt;
    a = rq.alpha;
    b = rq.beta;
    n = rq.degree;
    if (a <= -ONE_Q16 || b <= -ONE_Q16) begin
      bt = '{64'd0, 5'd0, 1'b1, 1'b1};
      expected_coeffs.push_back(bt);
      bad_requests++;
      return;
    end
    if (n > MAX_DEGREE) n = MAX_DEGREE;
    if (n >= 10) deep_requests++;
    c = a + b;
    g = a - b;
    for (int k = 0; k <= MAX_DEGREE; k++) begin
      prev[k] = '0;
      cur[k] = '0;
    end
    prev[0] = ONE_Q32;
    cur[0] = 64'(g * 32768);
    cur[1] = 64'(c * 32768) + ONE_Q32;
    for (int i = 1; i < n; i++) begin
      ii = longint'(i) * ONE_Q16;
      f1 = ii + ONE_Q16 + c;
      f2 = 2 * ii + c;
      f3 = 2 * ii + ONE_Q16 + c;
      f4 = 2 * ii + 2 * ONE_Q16 + c;
      m1 = (f1 < 0) ? 64'(-f1) : 64'(f1);
      m2 = (f2 < 0) ? 64'(-f2) : 64'(f2);
      a1 = 64'd2 * 64'(i + 1) * m1 * m2;
      neg_a1 = (f1 < 0) != (f2 < 0);
      a2 = q16_product(q16_product(f3, c), g);
      a3 = q16_product(q16_product(f2, f3), f4);
      a4 = 2 * q16_product(q16_product(a + ii, b + ii), f4);
      for (int k = 0; k <= MAX_DEGREE; k++) nxt[k] = '0;
      for (int k = 0; k <= i + 1; k++) begin
        s = wide_product(a2, cur[k]);
        if (k > 0) s = s + wide_product(a3, cur[k-1]);
        s = s - wide_product(a4, prev[k]);
        if (neg_a1) s = -s;
        nxt[k] = rounded_quotient(s, a1);
      end
      prev = cur;
      cur = nxt;
    end
    for (int k = 0; k <= n; k++) begin
      bt.coefficient = (n == 0) ? prev[k] : cur[k];
      bt.power_index = 5'(k);
      bt.last = (k == n);
      bt.bad_parameter = 1'b0;
      expected_coeffs.push_back(bt);
    end
  endtask

  // idle rates change with progress through the stimulus
  function automatic int sender_idle_pct();
    if (requests_taken < 110) return 36;
    if (requests_taken < 220) return 49;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (requests_taken < 110) return 49;
    if (requests_taken < 220) return 36;
    return 0;
  endfunction

  // request driver
  always @(posedge clk) begin
    request_t nx;
    if (rst) begin
      request_valid <= 1'b0;
    end else begin
      if (request_valid && request_ready) begin
        predict_coefficients('{alpha, beta, degree});
        requests_taken++;
      end
      if (!request_valid || request_ready) begin
        if (pending_requests.size() > 0 &&
            $urandom_range(99) >= sender_idle_pct()) begin
          nx = pending_requests.pop_front();
          alpha <= nx.alpha;
          beta <= nx.beta;
          degree <= nx.degree;
          request_valid <= 1'b1;
        end else begin
          request_valid <= 1'b0;
        end
      end
    end
  end

  // result sink, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (!hold_done && hold_count == 0 && requests_taken >= 40)
        hold_count = HOLD_CYCLES;
      if (hold_count > 0) begin
        hold_count--;
        if (hold_count == 0) hold_done = 1'b1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= receiver_idle_pct());
      end
    end
  end

  // coefficient checker
  always @(posedge clk) begin
    coeff_beat_t ex;
    if (!rst && result_valid && result_ready) begin
      beats_checked++;
      if (expected_coeffs.size() == 0) begin
        $display("%0t: unexpected beat coefficient=%h power=%0d", $time,
                 coefficient, power_index);
        errors++;
      end else begin
        ex = expected_coeffs.pop_front();
        if (coefficient !== ex.coefficient) begin
          $display("%0t: coefficient expected %h actual %h", $time,
                   ex.coefficient, coefficient);
          errors++;
        end
        if (power_index !== ex.power_index) begin
          $display("%0t: power_index expected %0d actual %0d", $time,
                   ex.power_index, power_index);
          errors++;
        end
        if (last !== ex.last) begin
          $display("%0t: last expected %0b actual %0b", $time, ex.last, last);
          errors++;
        end
        if (bad_parameter !== ex.bad_parameter) begin
          $display("%0t: bad_parameter expected %0b actual %0b", $time,
                   ex.bad_parameter, bad_parameter);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic add_request(input logic [23:0] a, input logic [23:0] b,
                             input logic [4:0] d);
    pending_requests.push_back('{a, b, d});
  endtask

  function automatic logic [23:0] random_parameter();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 24'($urandom);
    if (r < 20) return 24'(-$urandom_range(65535));
    return 24'($urandom_range(4 * ONE_Q16));
  endfunction

  function automatic logic [4:0] random_degree();
    int r;
    r = $urandom_range(99);
    if (r < 80) return 5'($urandom_range(6));
    if (r < 96) return 5'($urandom_range(10, 7));
    return 5'($urandom_range(31, 11));
  endfunction

  initial begin
    // directed: zero and unit parameters, edges of the valid range,
    // bad alpha and bad beta, full-scale values, degree clamping
    add_request(24'd0, 24'd0, 5'd0);
    add_request(24'd0, 24'd0, 5'd1);
    add_request(24'd0, 24'd0, 5'd2);
    add_request(24'd65536, 24'd65536, 5'd4);
    add_request(-24'sd65536, 24'd0, 5'd3);
    add_request(24'd0, -24'sd65536, 5'd3);
    add_request(-24'sd8388608, -24'sd8388608, 5'd5);
    add_request(-24'sd65535, -24'sd65535, 5'd3);
    add_request(-24'sd65535, 24'd0, 5'd5);
    add_request(24'd8388607, 24'd8388607, 5'd4);
    add_request(24'd8388607, 24'd0, 5'd3);
    add_request(24'd0, 24'd8388607, 5'd3);
    add_request(-24'sd32768, -24'sd32768, 5'd6);
    add_request(24'd32768, -24'sd32768, 5'd5);
    add_request(24'h555555, 24'h2AAAAA, 5'd2);
    add_request(24'h2AAAAA, 24'h555555, 5'd2);
    add_request(24'd98304, 24'd32768, 5'd16);
    add_request(24'd0, 24'd0, 5'd17);
    add_request(24'd65536, 24'd0, 5'd31);
    add_request(24'd12345, 24'd54321, 5'd8);
    for (int i = 0; i < 310; i++) begin
      add_request(random_parameter(), random_parameter(), random_degree());
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() > 0 || request_valid) @(posedge clk);
    while (expected_coeffs.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d requests (%0d bad parameter, %0d of degree 10 or more)",
             requests_taken, bad_requests, deep_requests);
    $display("checked %0d coefficient beats", beats_checked);
    if (errors == 0 && expected_coeffs.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
